### rtl/ffsa_pkg.sv
// ----------------------------------------------------------------------------
// ffsa_pkg
// shared constants, codes and types of the first-fit segment allocator
// ----------------------------------------------------------------------------
package ffsa_pkg;

    localparam int ARENA_BYTES  = 4096;
    localparam int HEADER_BYTES = 16;
    localparam int MAX_SEGMENTS = 64;

    localparam int OFF_W  = 12;
    localparam int SIZE_W = 13;
    localparam int NEED_W = 14;
    localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOFIT   = 2'd1;
    localparam logic [1:0] ST_BADADDR = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [OFF_W-1:0]  HDR_OFF  = OFF_W'(HEADER_BYTES);
    localparam logic [SIZE_W-1:0] HDR_SIZE = SIZE_W'(HEADER_BYTES);
    localparam logic [NEED_W-1:0] HDR_NEED = NEED_W'(HEADER_BYTES);

    typedef struct packed {
        logic              valid;
        logic              free;
        logic [OFF_W-1:0]  off;
        logic [SIZE_W-1:0] size;
    } seg_t;

    typedef struct packed {
        logic             valid;
        logic             found;
        logic             pf;
        logic             nf;
        logic [OFF_W-1:0] off;
    } tok_t;

    typedef struct packed {
        logic              start;
        logic              commit;
        logic              op;
        logic [SIZE_W-1:0] req;
        logic [OFF_W-1:0]  addr;
        logic              pf;
        logic              nf;
    } cmd_t;

    localparam seg_t SEG_INIT = '{valid: 1'b1, free: 1'b1, off: '0,
                                  size: SIZE_W'(ARENA_BYTES - HEADER_BYTES)};

endpackage

### rtl/ffsa_if.sv
// ----------------------------------------------------------------------------
// ffsa_req_if / ffsa_rsp_if
// valid/ready channels for request and response beats
// ----------------------------------------------------------------------------
interface ffsa_req_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [12:0] req_size;
    logic [11:0] release_addr;

    modport source (output valid, opcode, req_size, release_addr, input ready);
    modport sink   (input valid, opcode, req_size, release_addr, output ready);
endinterface

interface ffsa_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [11:0] payload_addr;

    modport source (output valid, status, payload_addr, input ready);
    modport sink   (input valid, status, payload_addr, output ready);
endinterface

### rtl/first_fit_segment_allocator_unit.sv
// ----------------------------------------------------------------------------
// first_fit_segment_allocator_unit
// first-fit arena allocator with split on allocate and coalescing on free
// ----------------------------------------------------------------------------
// req channel: one beat per request; opcode 0 allocates req_size payload
// bytes, opcode 1 frees the segment whose payload starts at release_addr.
// rsp channel: one beat per request with status and payload_addr.
// the segment table is a row of 64 cells in address order. a search token
// enters cell 0 and moves one cell per cycle; the first matching cell stamps
// it with its offset and the free marks of its neighbors. after the token
// leaves the last cell, the commit splits, merges and shifts all cells
// at once by handing entries to their neighbors.
// a request passes through the launch state, the token walk over the 64
// cells and the done state, which decides, commits on status ok and loads
// the output register; one request is in work at a time, so the next is
// not taken before the last has left the done state.
// reset leaves one free segment covering the whole arena; no clearing pass.
// a stalled response is held in its output register; the next request is
// taken, but its commit waits until that response beat has gone.
// ----------------------------------------------------------------------------
module first_fit_segment_allocator_unit (
    input  logic       clk,
    input  logic       rst_n,
    ffsa_req_if.sink   req,
    ffsa_rsp_if.source rsp
);

    localparam int N = ffsa_pkg::MAX_SEGMENTS;

    ffsa_pkg::cmd_t cmd;
    ffsa_pkg::tok_t tok [N+1];
    ffsa_pkg::seg_t seg [N+2];
    logic           sel [N+1];

    ffsa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .rsp      (rsp),
        .cmd      (cmd),
        .tok_head (tok[0]),
        .tok_tail (tok[N])
    );

    assign seg[N]   = '0;
    assign seg[N+1] = '0;
    assign sel[N]   = 1'b0;

    for (genvar k = 0; k < N; k++)
    begin : g_cell
        ffsa_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .first     (k == 0),
            .cmd       (cmd),
            .tok_in    (tok[k]),
            .tok_out   (tok[k+1]),
            .prev_seg  ((k == 0) ? '0 : seg[(k == 0) ? 0 : k-1]),
            .next_seg  (seg[k+1]),
            .next2_seg (seg[k+2]),
            .prev_sel  ((k == 0) ? 1'b0 : sel[(k == 0) ? 0 : k-1]),
            .next_sel  (sel[k+1]),
            .seg       (seg[k]),
            .sel       (sel[k])
        );
    end

endmodule

### rtl/ffsa_cell.sv
// ----------------------------------------------------------------------------
// ffsa_cell
// one table entry: local fit check, search token pass-on, shift and merge
// ----------------------------------------------------------------------------
module ffsa_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           first,
    input  ffsa_pkg::cmd_t cmd,
    input  ffsa_pkg::tok_t tok_in,
    output ffsa_pkg::tok_t tok_out,
    input  ffsa_pkg::seg_t prev_seg,
    input  ffsa_pkg::seg_t next_seg,
    input  ffsa_pkg::seg_t next2_seg,
    input  logic           prev_sel,
    input  logic           next_sel,
    output ffsa_pkg::seg_t seg,
    output logic           sel
);

    ffsa_pkg::seg_t seg_reg, seg_next;
    ffsa_pkg::tok_t tok_reg, tok_next;
    logic           sel_reg, sel_next;
    logic           reach_reg, reach_next;
    logic [ffsa_pkg::NEED_W-1:0] need;
    logic           hit;
    logic           take;
    logic [1:0]     shift;

    assign need = {1'b0, cmd.req} + ffsa_pkg::HDR_NEED;
    assign hit  = seg_reg.valid & ((cmd.op == ffsa_pkg::OP_FREE)
                ? (!seg_reg.free && (seg_reg.off + ffsa_pkg::HDR_OFF) == cmd.addr)
                : (seg_reg.free && {1'b0, seg_reg.size} >= need));
    assign take  = tok_in.valid & !tok_in.found & hit;
    assign shift = {1'b0, cmd.pf} + {1'b0, cmd.nf};

    always_comb
    begin
        tok_next   = tok_in;
        sel_next   = sel_reg;
        reach_next = reach_reg;
        if (take)
        begin
            tok_next.found = 1'b1;
            tok_next.pf    = prev_seg.valid & prev_seg.free;
            tok_next.nf    = next_seg.valid & next_seg.free;
            tok_next.off   = seg_reg.off;
        end
        if (cmd.start)
        begin
            sel_next   = 1'b0;
            reach_next = 1'b0;
        end
        else if (tok_in.valid && !tok_in.found)
        begin
            reach_next = 1'b1;
            sel_next   = hit;
        end
    end

    always_comb
    begin
        seg_next = seg_reg;
        if (cmd.commit)
        begin
            if (cmd.op == ffsa_pkg::OP_ALLOC)
            begin
                if (sel_reg)
                begin
                    seg_next.size = cmd.req;
                    seg_next.free = 1'b0;
                end
                else if (prev_sel)
                begin
                    seg_next.valid = 1'b1;
                    seg_next.free  = 1'b1;
                    seg_next.off   = prev_seg.off + need[ffsa_pkg::OFF_W-1:0];
                    seg_next.size  = prev_seg.size - need[ffsa_pkg::SIZE_W-1:0];
                end
                else if (!reach_reg)
                begin
                    seg_next = prev_seg;
                end
            end
            else
            begin
                if (sel_reg)
                begin
                    if (cmd.pf)
                    begin
                        seg_next = cmd.nf ? next2_seg : next_seg;
                    end
                    else
                    begin
                        seg_next.free = 1'b1;
                        if (cmd.nf)
                        begin
                            seg_next.size = seg_reg.size + ffsa_pkg::HDR_SIZE + next_seg.size;
                        end
                    end
                end
                else if (next_sel && cmd.pf)
                begin
                    seg_next.size = seg_reg.size + ffsa_pkg::HDR_SIZE + next_seg.size
                                  + (cmd.nf ? (ffsa_pkg::HDR_SIZE + next2_seg.size) : '0);
                end
                else if (!reach_reg)
                begin
                    case (shift)
                        2'd1:    seg_next = next_seg;
                        2'd2:    seg_next = next2_seg;
                        default: seg_next = seg_reg;
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_reg   <= first ? ffsa_pkg::SEG_INIT : '0;
            tok_reg   <= '0;
            sel_reg   <= 1'b0;
            reach_reg <= 1'b0;
        end
        else
        begin
            seg_reg   <= seg_next;
            tok_reg   <= tok_next;
            sel_reg   <= sel_next;
            reach_reg <= reach_next;
        end
    end

    assign seg     = seg_reg;
    assign sel     = sel_reg;
    assign tok_out = tok_reg;

endmodule

### rtl/ffsa_ctrl.sv
// ----------------------------------------------------------------------------
// ffsa_ctrl
// request sequencer: token launch, decision, commit and response register
// ----------------------------------------------------------------------------
module ffsa_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    ffsa_req_if.sink       req,
    ffsa_rsp_if.source     rsp,
    output ffsa_pkg::cmd_t cmd,
    output ffsa_pkg::tok_t tok_head,
    input  ffsa_pkg::tok_t tok_tail
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_WALK  = 3'd2;
    localparam logic [2:0] S_DONE  = 3'd3;

    logic [2:0] state_reg, state_next;
    logic       op_reg, op_next;
    logic [ffsa_pkg::SIZE_W-1:0] size_reg, size_next;
    logic [ffsa_pkg::OFF_W-1:0]  addr_reg, addr_next;
    logic [ffsa_pkg::CNT_W-1:0]  count_reg, count_next;
    logic       inject_reg, inject_next;
    ffsa_pkg::tok_t res_reg, res_next;
    logic       out_valid_reg, out_valid_next;
    logic [1:0] status_reg, status_next;
    logic [ffsa_pkg::OFF_W-1:0] paddr_reg, paddr_next;
    logic       fire;
    logic       full;
    logic       commit;
    logic [1:0] st;

    assign full = count_reg == ffsa_pkg::CNT_W'(ffsa_pkg::MAX_SEGMENTS);
    assign fire = (state_reg == S_DONE) && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        if (op_reg == ffsa_pkg::OP_FREE)
        begin
            st = res_reg.found ? ffsa_pkg::ST_OK : ffsa_pkg::ST_BADADDR;
        end
        else if (!res_reg.found)
        begin
            st = ffsa_pkg::ST_NOFIT;
        end
        else
        begin
            st = full ? ffsa_pkg::ST_FULL : ffsa_pkg::ST_OK;
        end
    end

    assign commit = fire && (st == ffsa_pkg::ST_OK);

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        size_next      = size_reg;
        addr_next      = addr_reg;
        count_next     = count_reg;
        inject_next    = 1'b0;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        paddr_next     = paddr_reg;
        if (rsp.valid && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next    = req.opcode;
                    size_next  = req.req_size;
                    addr_next  = req.release_addr;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                inject_next = 1'b1;
                state_next  = S_WALK;
            end
            S_WALK:
            begin
                if (tok_tail.valid)
                begin
                    res_next   = tok_tail;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (fire)
                begin
                    out_valid_next = 1'b1;
                    status_next    = st;
                    paddr_next     = '0;
                    if (commit && op_reg == ffsa_pkg::OP_ALLOC)
                    begin
                        paddr_next = res_reg.off + ffsa_pkg::HDR_OFF;
                        count_next = count_reg + 1'b1;
                    end
                    else if (commit)
                    begin
                        count_next = count_reg - ffsa_pkg::CNT_W'(res_reg.pf)
                                   - ffsa_pkg::CNT_W'(res_reg.nf);
                    end
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= ffsa_pkg::CNT_W'(1);
            inject_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            inject_reg    <= inject_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        size_reg   <= size_next;
        addr_reg   <= addr_next;
        res_reg    <= res_next;
        status_reg <= status_next;
        paddr_reg  <= paddr_next;
    end

    assign req.ready        = state_reg == S_IDLE;
    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = status_reg;
    assign rsp.payload_addr = paddr_reg;

    assign cmd.start  = state_reg == S_START;
    assign cmd.commit = commit;
    assign cmd.op     = op_reg;
    assign cmd.req    = size_reg;
    assign cmd.addr   = addr_reg;
    assign cmd.pf     = res_reg.pf;
    assign cmd.nf     = res_reg.nf;

    assign tok_head = '{valid: inject_reg, found: 1'b0, pf: 1'b0, nf: 1'b0, off: '0};

endmodule
